>>> design/apg_pkg.sv
// ----------------------------------------------------------------------------
// apg_pkg
// Shared types and constants for the prompt geometry unit: character codes,
// result kinds, escape parser phases and the result record.
// ----------------------------------------------------------------------------
package apg_pkg;

	localparam int unsigned MAX_LINE_WIDTH_DEF = 4095;
	localparam int unsigned MAX_LINES_DEF      = 255;

	localparam int unsigned WIDTH_W = 12;
	localparam int unsigned LINES_W = 8;

	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_ESC      = 8'h1B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
	localparam logic [7:0] CH_LOWER_A  = 8'h61;
	localparam logic [7:0] CH_LOWER_Z  = 8'h7A;

	typedef enum logic [1:0] {
		KIND_CHAR    = 2'd0,
		KIND_BREAK   = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_TEXT = 2'd0,
		PH_ESC  = 2'd1,
		PH_CSI  = 2'd2
	} phase_t;

	typedef struct packed {
		kind_t                kind;
		logic [7:0]           char_out;
		logic [WIDTH_W-1:0]   widest_line;
		logic [LINES_W-1:0]   line_total;
		logic [WIDTH_W-1:0]   current_line_width;
		logic                 saw_escape;
		logic                 done_res;
	} res_t;

	function automatic logic is_letter(input logic [7:0] c);
		is_letter = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
			(c >= CH_LOWER_A && c <= CH_LOWER_Z);
	endfunction

endpackage

>>> design/ansi_prompt_geometry_unit.sv
// ----------------------------------------------------------------------------
// ansi_prompt_geometry_unit
// Strips ESC '[' control sequences from prompt text and reports line
// geometry: one item per visible byte, one per line break, one summary.
// ----------------------------------------------------------------------------
// usage:
//   the s_ channel takes one text byte per item in s_tdata, with s_tlast on
//   the final byte of the prompt. the m_ channel returns result items: kind
//   in m_tuser, done_res in m_tlast and the remaining fields in m_tdata.
//   a byte is parsed in the cycle it is accepted; its results are written
//   into a registered four-entry result queue that drives m_. the queue
//   drains one item per cycle while m_tready is high.
//   a byte that yields at most one result (the usual case) sustains one byte
//   per cycle while m_tready stays high. a byte can yield up to three results
//   (a lone ESC, the byte itself and the summary); the queue then holds the
//   extra items and s_tready drops until at most one entry will remain after
//   this cycle. when the receiver stalls, the queue fills and s_tready falls;
//   nothing is lost or repeated.
//   reset empties the queue and returns the parser to plain text with one
//   line of width zero. after the summary of a prompt the counters return
//   to that same state for the next prompt.
// ----------------------------------------------------------------------------
module ansi_prompt_geometry_unit #(
	parameter int unsigned MAX_LINE_WIDTH = apg_pkg::MAX_LINE_WIDTH_DEF,
	parameter int unsigned MAX_LINES      = apg_pkg::MAX_LINES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // text_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // char_out, widest_line, line_total,
	                               // current_line_width, saw_escape, zero fill
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast    // done_res
);
	import apg_pkg::*;

	localparam int unsigned WW = $clog2(MAX_LINE_WIDTH + 1);
	localparam int unsigned LW = $clog2(MAX_LINES + 1);

	typedef struct packed {
		logic [WW-1:0] width;
		logic [WW-1:0] widest;
		logic [LW-1:0] lines;
		logic          esc;
	} geom_t;

	localparam geom_t GEOM_RESET = '{width: '0, widest: '0, lines: LW'(1), esc: 1'b0};

	function automatic geom_t f_visible(input geom_t g);
		geom_t r;
		r = g;
		if (r.width < WW'(MAX_LINE_WIDTH))
			r.width = r.width + WW'(1);
		if (r.width > r.widest)
			r.widest = r.width;
		f_visible = r;
	endfunction

	function automatic geom_t f_break(input geom_t g);
		geom_t r;
		r = g;
		if (r.lines < LW'(MAX_LINES))
			r.lines = r.lines + LW'(1);
		r.width = '0;
		f_break = r;
	endfunction

	function automatic res_t f_pack(input geom_t g, input kind_t k, input logic [7:0] ch,
			input logic done);
		res_t r;
		r.kind               = k;
		r.char_out           = ch;
		r.widest_line        = WIDTH_W'(g.widest);
		r.line_total         = LINES_W'(g.lines);
		r.current_line_width = WIDTH_W'(g.width);
		r.saw_escape         = g.esc;
		r.done_res           = done;
		f_pack = r;
	endfunction

	// parser state
	phase_t phase_q;
	geom_t  geom_q;

	// result queue
	res_t       fifo_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] cnt_q;

	logic       accept;
	logic       pop;
	phase_t     ph;
	geom_t      g;
	res_t       res [3];
	logic [1:0] n_res;
	logic [7:0] c;
	res_t       head;

	assign c        = s_tdata;
	assign m_tvalid = (cnt_q != 3'd0);
	assign pop      = m_tvalid && m_tready;
	// room for three more entries once this cycle's pop is counted
	assign s_tready = (cnt_q <= 3'd1) || (cnt_q == 3'd2 && m_tready);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		ph    = phase_q;
		g     = geom_q;
		n_res = 2'd0;
		for (int k = 0; k < 3; k++)
			res[k] = '0;

		if (c != CH_NUL) begin
			case (ph)
				PH_ESC: begin
					if (c == CH_LBRACKET) begin
						ph    = PH_CSI;
						g.esc = 1'b1;
					end else begin
						// lone escape shows as a character, then the byte is plain text
						g          = f_visible(g);
						res[n_res] = f_pack(g, KIND_CHAR, CH_ESC, 1'b0);
						n_res      = n_res + 2'd1;
						ph         = PH_TEXT;
						if (c == CH_ESC) begin
							ph = PH_ESC;
						end else if (c == CH_NEWLINE) begin
							g          = f_break(g);
							res[n_res] = f_pack(g, KIND_BREAK, CH_NUL, 1'b0);
							n_res      = n_res + 2'd1;
						end else begin
							g          = f_visible(g);
							res[n_res] = f_pack(g, KIND_CHAR, c, 1'b0);
							n_res      = n_res + 2'd1;
						end
					end
				end
				PH_CSI: begin
					if (c == CH_NEWLINE) begin
						ph         = PH_TEXT;
						g          = f_break(g);
						res[n_res] = f_pack(g, KIND_BREAK, CH_NUL, 1'b0);
						n_res      = n_res + 2'd1;
					end else if (is_letter(c)) begin
						ph = PH_TEXT;
					end
				end
				default: begin
					ph = PH_TEXT;
					if (c == CH_ESC) begin
						ph = PH_ESC;
					end else if (c == CH_NEWLINE) begin
						g          = f_break(g);
						res[n_res] = f_pack(g, KIND_BREAK, CH_NUL, 1'b0);
						n_res      = n_res + 2'd1;
					end else begin
						g          = f_visible(g);
						res[n_res] = f_pack(g, KIND_CHAR, c, 1'b0);
						n_res      = n_res + 2'd1;
					end
				end
			endcase
		end

		if (s_tlast) begin
			if (ph == PH_ESC) begin
				g          = f_visible(g);
				res[n_res] = f_pack(g, KIND_CHAR, CH_ESC, 1'b0);
				n_res      = n_res + 2'd1;
			end
			res[n_res] = f_pack(g, KIND_SUMMARY, CH_NUL, 1'b1);
			n_res      = n_res + 2'd1;
			ph         = PH_TEXT;
			g          = GEOM_RESET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TEXT;
			geom_q  <= GEOM_RESET;
		end else if (accept) begin
			phase_q <= ph;
			geom_q  <= g;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (accept && 2'(k) < n_res)
				fifo_q[2'(wr_ptr_q + 2'(k))] <= res[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept)
				wr_ptr_q <= wr_ptr_q + n_res;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + (accept ? {1'b0, n_res} : 3'd0) - (pop ? 3'd1 : 3'd0);
		end
	end

	assign head    = fifo_q[rd_ptr_q];
	assign m_tuser = head.kind;
	assign m_tlast = head.done_res;
	assign m_tdata = {7'd0, head.saw_escape, head.current_line_width, head.line_total,
		head.widest_line, head.char_out};

	// queue never overflows
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result queue overflow");

	// a summary item is always flagged as the end of the text
	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == KIND_SUMMARY)))
		else $error("summary and done flag disagree");

	// the end of a text returns the parser to its starting state
	a_text_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tlast |=> phase_q == PH_TEXT && geom_q == GEOM_RESET)
		else $error("parser not restarted after end of text");

	// every accepted final byte queues at least its summary
	a_summary_queued: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tlast |-> n_res != 2'd0)
		else $error("final byte produced no summary");

endmodule

>>> tb/sv/tb_ansi_prompt_geometry_unit.sv
// ----------------------------------------------------------------------------
// tb_ansi_prompt_geometry_unit
// Streams prompt text into the geometry unit and checks every result item
// against a behavioral predictor of the escape stripper and line counters.
// A short table of directed bytes comes first. It is followed by random
// prompts built from plain text, CSI sequences, lone escapes, newlines and NULs.
// The sender idles in bursts and the receiver stalls, with one long hold-off.
// ----------------------------------------------------------------------------
module tb_ansi_prompt_geometry_unit;
	import apg_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 40000;
	localparam int unsigned DIR_ROWS    = 25;
	localparam int unsigned RAND_ITEMS  = 225;
	localparam res_t        NO_RES      = '0;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       typed;
		res_t       want;
	} text_item_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // text_byte
	logic        s_tlast;   // last_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // char_out, widest_line, line_total,
	                        // current_line_width, saw_escape, zero fill
	logic [1:0]  m_tuser;   // kind
	logic        m_tlast;   // done_res

	ansi_prompt_geometry_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	text_item_t  text_q[$];
	text_item_t  dir_tab [DIR_ROWS];
	res_t        expected_q[$];
	res_t        step_q[$];
	int unsigned err_cnt;
	int unsigned accepted_cnt;
	int unsigned result_cnt;
	int unsigned cycle_cnt;

	// predictor state
	phase_t      esc_st;
	int unsigned cur_w;
	int unsigned widest_w;
	int unsigned line_cnt;
	logic        csi_flag;

	function automatic logic alpha_byte(input logic [7:0] c);
		return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
	endfunction

	function automatic void emit(input kind_t k, input logic [7:0] ch, input logic done);
		res_t r;
		r.kind               = k;
		r.char_out           = ch;
		r.widest_line        = widest_w[WIDTH_W-1:0];
		r.line_total         = line_cnt[LINES_W-1:0];
		r.current_line_width = cur_w[WIDTH_W-1:0];
		r.saw_escape         = csi_flag;
		r.done_res           = done;
		step_q.push_back(r);
	endfunction

	function automatic void clear_text();
		esc_st   = PH_TEXT;
		cur_w    = 0;
		widest_w = 0;
		line_cnt = 1;
		csi_flag = 1'b0;
	endfunction

	function automatic void show_char(input logic [7:0] ch);
		if (cur_w < MAX_LINE_WIDTH_DEF) begin
			cur_w++;
		end
		if (cur_w > widest_w) begin
			widest_w = cur_w;
		end
		emit(KIND_CHAR, ch, 1'b0);
	endfunction

	function automatic void break_line();
		if (line_cnt < MAX_LINES_DEF) begin
			line_cnt++;
		end
		cur_w  = 0;
		esc_st = PH_TEXT;
		emit(KIND_BREAK, CH_NUL, 1'b0);
	endfunction

	function automatic void plain_byte(input logic [7:0] c);
		if (c == CH_ESC) begin
			esc_st = PH_ESC;
		end else if (c == CH_NEWLINE) begin
			break_line();
		end else begin
			show_char(c);
		end
	endfunction

	// fills step_q with the result items caused by one text byte
	function automatic void parse_byte(input logic [7:0] c, input logic last);
		step_q.delete();
		if (c != CH_NUL) begin
			case (esc_st)
				PH_ESC: begin
					if (c == CH_LBRACKET) begin
						esc_st   = PH_CSI;
						csi_flag = 1'b1;
					end else begin
						// lone escape shows up as a visible char
						esc_st = PH_TEXT;
						show_char(CH_ESC);
						plain_byte(c);
					end
				end
				PH_CSI: begin
					if (c == CH_NEWLINE) begin
						break_line();
					end else if (alpha_byte(c)) begin
						esc_st = PH_TEXT;
					end
				end
				default: begin
					esc_st = PH_TEXT;
					plain_byte(c);
				end
			endcase
		end
		if (last) begin
			if (esc_st == PH_ESC) begin
				esc_st = PH_TEXT;
				show_char(CH_ESC);
			end
			emit(KIND_SUMMARY, CH_NUL, 1'b1);
			clear_text();
		end
	endfunction

	task automatic report(input string what, input int unsigned got, input int unsigned want);
		$display("mismatch in result %0d: %s got %0h expected %0h", result_cnt, what, got, want);
		err_cnt++;
	endtask

	task automatic add_byte(input logic [7:0] c, input logic last);
		text_q.push_back('{c, last, 1'b0, NO_RES});
	endtask

	// one random piece of prompt text, mostly well formed
	task automatic add_token();
		int unsigned pick;
		int unsigned n;
		logic [7:0]  b;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			add_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
		end else if (pick < 45) begin
			add_byte(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
		end else if (pick < 60 || (pick >= 80 && pick < 88)) begin
			add_byte(CH_ESC, 1'b0);
			add_byte(CH_LBRACKET, 1'b0);
			n = $urandom_range(0, 3);
			repeat (n) add_byte(8'($urandom_range(8'h30, 8'h3B)), 1'b0);
			if (pick >= 80) begin
				// sequence cut short by a newline
				add_byte(CH_NEWLINE, 1'b0);
			end else if ($urandom_range(0, 1) != 0) begin
				add_byte(8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)), 1'b0);
			end else begin
				add_byte(8'($urandom_range(CH_LOWER_A, CH_LOWER_Z)), 1'b0);
			end
		end else if (pick < 72) begin
			add_byte(CH_NEWLINE, 1'b0);
		end else if (pick < 80) begin
			do b = 8'($urandom_range(0, 255)); while (b == CH_LBRACKET);
			add_byte(CH_ESC, 1'b0);
			add_byte(b, 1'b0);
		end else if (pick < 93) begin
			add_byte(CH_NUL, 1'b0);
		end else begin
			add_byte(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// receiver: changing stall pattern plus one long hold-off
	initial begin
		int unsigned mode;
		int unsigned hold_left;
		logic        hold_done;
		mode      = 0;
		hold_left = 0;
		hold_done = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && accepted_cnt >= 100) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if ($urandom_range(0, 63) == 0) begin
					mode = $urandom_range(0, 3);
				end
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ~m_tready;
				endcase
			end
		end
	end

	// predict on every accepted byte, check every accepted result
	always @(posedge clk) begin
		text_item_t it;
		res_t       got;
		res_t       want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				it = text_q[accepted_cnt];
				accepted_cnt++;
				parse_byte(s_tdata, s_tlast);
				if (it.typed) begin
					expected_q.push_back(it.want);
				end else begin
					foreach (step_q[i]) expected_q.push_back(step_q[i]);
				end
			end
			if (m_tvalid && m_tready) begin
				got.kind               = kind_t'(m_tuser);
				got.char_out           = m_tdata[7:0];
				got.widest_line        = m_tdata[19:8];
				got.line_total         = m_tdata[27:20];
				got.current_line_width = m_tdata[39:28];
				got.saw_escape         = m_tdata[40];
				got.done_res           = m_tlast;
				if (expected_q.size() == 0) begin
					report("unexpected item kind", got.kind, 0);
				end else begin
					want = expected_q.pop_front();
					if (got.kind !== want.kind)
						report("kind", got.kind, want.kind);
					if (got.char_out !== want.char_out)
						report("char_out", got.char_out, want.char_out);
					if (got.widest_line !== want.widest_line)
						report("widest_line", got.widest_line, want.widest_line);
					if (got.line_total !== want.line_total)
						report("line_total", got.line_total, want.line_total);
					if (got.current_line_width !== want.current_line_width)
						report("current_line_width", got.current_line_width,
							want.current_line_width);
					if (got.saw_escape !== want.saw_escape)
						report("saw_escape", got.saw_escape, want.saw_escape);
					if (got.done_res !== want.done_res)
						report("done_res", got.done_res, want.done_res);
				end
				result_cnt++;
			end
		end
	end

	// sender: builds the whole text, then offers it in bursts
	initial begin
		int unsigned burst_left;
		int unsigned gap;
		int unsigned base;
		int unsigned tokens;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		s_tlast  <= 1'b0;
		clear_text();

		dir_tab = '{
			'{CH_NUL, 1'b1, 1'b1, '{KIND_SUMMARY, 8'h00, 12'd0, 8'd1, 12'd0, 1'b0, 1'b1}},
			'{CH_UPPER_A, 1'b0, 1'b1, '{KIND_CHAR, CH_UPPER_A, 12'd1, 8'd1, 12'd1, 1'b0, 1'b0}},
			'{8'hFF, 1'b0, 1'b0, NO_RES},
			'{CH_NEWLINE, 1'b0, 1'b1, '{KIND_BREAK, 8'h00, 12'd2, 8'd2, 12'd0, 1'b0, 1'b0}},
			'{CH_ESC, 1'b0, 1'b0, NO_RES},
			'{CH_LBRACKET, 1'b0, 1'b0, NO_RES},
			'{8'h30, 1'b0, 1'b0, NO_RES},
			'{8'h40, 1'b0, 1'b0, NO_RES},    // just below 'A'
			'{8'h7B, 1'b0, 1'b0, NO_RES},    // just above 'z'
			'{8'h60, 1'b0, 1'b0, NO_RES},    // just below 'a'
			'{CH_UPPER_Z, 1'b0, 1'b0, NO_RES},
			'{CH_ESC, 1'b0, 1'b0, NO_RES},
			'{CH_LBRACKET, 1'b0, 1'b0, NO_RES},
			'{CH_LOWER_A, 1'b0, 1'b0, NO_RES},
			'{CH_ESC, 1'b0, 1'b0, NO_RES},
			'{8'h78, 1'b0, 1'b0, NO_RES},    // lone escape then plain char
			'{CH_ESC, 1'b0, 1'b0, NO_RES},
			'{CH_NEWLINE, 1'b0, 1'b0, NO_RES},
			'{CH_ESC, 1'b0, 1'b0, NO_RES},
			'{CH_LBRACKET, 1'b0, 1'b0, NO_RES},
			'{CH_NEWLINE, 1'b0, 1'b0, NO_RES}, // newline ends the sequence
			'{CH_NUL, 1'b0, 1'b0, NO_RES},
			'{CH_ESC, 1'b1, 1'b0, NO_RES},   // escape pending at end of text
			'{CH_ESC, 1'b0, 1'b0, NO_RES},
			'{CH_LOWER_Z, 1'b1, 1'b0, NO_RES} // three items from one byte
		};
		foreach (dir_tab[i]) text_q.push_back(dir_tab[i]);

		base = text_q.size();
		while (text_q.size() < base + RAND_ITEMS) begin
			tokens = $urandom_range(1, 20);
			repeat (tokens) add_token();
			if ($urandom_range(0, 9) == 0) begin
				add_byte(CH_NUL, 1'b1);
			end else begin
				text_q[text_q.size()-1].last = 1'b1;
			end
		end

		wait (arst_n === 1'b1);
		@(posedge clk);
		burst_left = 0;
		foreach (text_q[i]) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			s_tvalid <= 1'b1;
			s_tdata  <= text_q[i].ch;
			s_tlast  <= text_q[i].last;
			do @(posedge clk); while (!s_tready);
			burst_left--;
		end
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (32) @(posedge clk);
		if (err_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
design/apg_pkg.sv
design/ansi_prompt_geometry_unit.sv
tb/sv/tb_ansi_prompt_geometry_unit.sv
